FILE: hw/rtl/uvs_pkg.sv
// uvs_pkg: shared types, field widths and constants of the uv sphere vertex generator
// also holds the elaboration-time builder of the quarter-wave sine table
// no dependencies
package uvs_pkg;

    localparam int MAX_SEGMENTS_DEF    = 64;
    localparam int SINE_TABLE_BITS_DEF = 12;

    localparam int SEG_W       = 7;
    localparam int RAD_W       = 16;
    localparam int IDX_W       = 6;
    localparam int POS_W       = 17;
    localparam int SLOT_W      = 3;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 56;
    localparam int SINE_MAG_W  = 15;

    localparam logic [SEG_W-1:0]  SEGMENTS_RST = 7'd16;
    localparam logic [RAD_W-1:0]  RADIUS_RST   = 16'd256;
    localparam logic [SLOT_W-1:0] SLOT_FIRST   = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_LAST    = 3'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEGMENTS = 1'b0,
        CFG_RADIUS   = 1'b1
    } t_cfg_reg;

    // control that travels with each vertex down the pipeline
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              pole;
        logic              bad;
        logic              last;
    } t_vtx_tag;

    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
    localparam logic [63:0] PI_Q30 = (PI_Q60 + (64'd1 << 29)) >> 30;

    // quarter-wave entry k of a 2^b table: round(32767*sin), taylor series in q30
    function automatic logic [SINE_MAG_W-1:0] f_qsin(input int k, input int b);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] v;
        x  = (PI_Q30 * 64'(k)) >> (b - 1);
        x2 = (x * x) >> 30;
        t  = x;
        s  = x;
        t = ((t * x2) >> 30) / 64'd6;   s = s - t;
        t = ((t * x2) >> 30) / 64'd20;  s = s + t;
        t = ((t * x2) >> 30) / 64'd42;  s = s - t;
        t = ((t * x2) >> 30) / 64'd72;  s = s + t;
        t = ((t * x2) >> 30) / 64'd110; s = s - t;
        t = ((t * x2) >> 30) / 64'd156; s = s + t;
        t = ((t * x2) >> 30) / 64'd210; s = s - t;
        t = ((t * x2) >> 30) / 64'd272; s = s + t;
        v = (64'd32767 * s + (64'd1 << 29)) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[SINE_MAG_W-1:0];
    endfunction

endpackage

FILE: hw/rtl/uv_sphere_cell_vertex_generator.sv
// uv_sphere_cell_vertex_generator: top level, cell expander, multiply and rounding stages
// depends on uvs_pkg, uvs_angle_div, uvs_sincos
//
// usage:
//   input stream carries one grid cell per item: ring_index in tdata[5:0] and
//   segment_index in tdata[11:6]. each valid cell gives six vertex items on the
//   output stream (two triangles), slots 0..5 on consecutive unstalled cycles, tlast
//   on slot 5. a cell whose ring or segment is not below the segment count gives
//   one item with zero coordinates, tuser (bad index) and tlast set.
//   configuration channel: index 0 writes the segment count (data[6:0], values
//   above MAX_SEGMENTS act as MAX_SEGMENTS), index 1 the radius (q8.8). write only
//   while no cell is in flight.
//   the first vertex reaches the output through the cell expander, the divider, the
//   sincos and multiply stages and the output register; the divider pipeline, one
//   quotient bit per stage, sets most of the delay. a new cell is taken in the cycle
//   its predecessor's last vertex enters the pipeline, so cells follow with no gap,
//   bounded by the one vertex per cycle of the output channel while it is not stalled.
//   reset: segment count 16, radius 1.0, pipeline empty.
//   stall: while an output item waits, the whole pipeline holds in place.
module uv_sphere_cell_vertex_generator #(
    parameter int MAX_SEGMENTS    = uvs_pkg::MAX_SEGMENTS_DEF,
    parameter int SINE_TABLE_BITS = uvs_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [5:0] ring_index, [11:6] segment_index, [15:12] zero
    input  logic [uvs_pkg::S_TDATA_W-1:0]     i_s_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [16:0] pos_x, [33:17] pos_y, [50:34] pos_z, [53:51] vertex_slot, [55:54] zero
    output logic [uvs_pkg::M_TDATA_W-1:0]     o_m_axis_tdata,
    output logic                              o_m_axis_tlast,
    // [0] bad_index
    output logic                              o_m_axis_tuser,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [uvs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [uvs_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import uvs_pkg::*;

    localparam int NW = $clog2(MAX_SEGMENTS + 1);
    localparam int CW = (NW > SEG_W) ? NW : SEG_W;
    localparam int B  = SINE_TABLE_BITS;

    // configuration
    logic [SEG_W-1:0] r_segments;
    logic [RAD_W-1:0] r_radius;
    logic [NW-1:0]    w_n;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_segments <= SEGMENTS_RST;
            r_radius   <= RADIUS_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_SEGMENTS: r_segments <= i_cfg_data[SEG_W-1:0];
                CFG_RADIUS:   r_radius   <= i_cfg_data[RAD_W-1:0];
                default:      r_segments <= r_segments;
            endcase
        end
    end

    assign w_n = (32'(r_segments) > MAX_SEGMENTS) ? NW'(MAX_SEGMENTS) : NW'(r_segments);

    // pipeline advance
    logic r_out_valid;
    logic w_en;

    assign w_en = !r_out_valid || i_m_axis_tready;

    // cell expander
    logic [IDX_W-1:0]  w_in_ring;
    logic [IDX_W-1:0]  w_in_seg;
    logic              w_in_bad;
    logic [NW-1:0]     w_in_seg_n;
    logic [NW-1:0]     w_in_seg_next;
    logic              w_accept;
    logic              w_last_issue;
    logic              r_busy;
    logic [SLOT_W-1:0] r_slot;
    logic [NW-1:0]     r_ring;
    logic [NW-1:0]     r_seg;
    logic [NW-1:0]     r_seg_next;
    logic              r_last_ring;
    logic              r_bad;

    assign w_in_ring     = i_s_axis_tdata[IDX_W-1:0];
    assign w_in_seg      = i_s_axis_tdata[2*IDX_W-1:IDX_W];
    assign w_in_bad      = (CW'(w_in_ring) >= CW'(w_n)) || (CW'(w_in_seg) >= CW'(w_n));
    assign w_in_seg_n    = NW'(w_in_seg);
    assign w_in_seg_next = (w_in_seg_n + NW'(1) == w_n) ? '0 : w_in_seg_n + NW'(1);

    assign w_last_issue    = r_bad || (r_slot == SLOT_LAST);
    assign o_s_axis_tready = !r_busy || (w_en && w_last_issue);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_slot <= SLOT_FIRST;
        end else if (w_accept) begin
            r_busy <= 1'b1;
            r_slot <= SLOT_FIRST;
        end else if (r_busy && w_en) begin
            if (w_last_issue) begin
                r_busy <= 1'b0;
            end else begin
                r_slot <= r_slot + SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ring      <= NW'(w_in_ring);
            r_seg       <= w_in_seg_n;
            r_seg_next  <= w_in_seg_next;
            r_last_ring <= (CW'(w_in_ring) + CW'(1)) == CW'(w_n);
            r_bad       <= w_in_bad;
        end
    end

    // slot order: (j,i) (j,i+1) (j+1,i) (j+1,i) (j,i+1) (j+1,i+1)
    logic     w_upper;
    logic     w_use_next;
    logic [NW-1:0] w_iss_ring;
    logic [NW-1:0] w_iss_seg;
    t_vtx_tag w_iss_tag;

    always_comb begin
        case (r_slot) inside
            3'd1, 3'd4: begin
                w_upper    = 1'b0;
                w_use_next = 1'b1;
            end
            3'd2, 3'd3: begin
                w_upper    = 1'b1;
                w_use_next = 1'b0;
            end
            3'd5: begin
                w_upper    = 1'b1;
                w_use_next = 1'b1;
            end
            default: begin
                w_upper    = 1'b0;
                w_use_next = 1'b0;
            end
        endcase
    end

    assign w_iss_ring     = r_ring + NW'(w_upper);
    assign w_iss_seg      = w_use_next ? r_seg_next : r_seg;
    assign w_iss_tag.slot = r_bad ? SLOT_FIRST : r_slot;
    assign w_iss_tag.pole = w_upper && r_last_ring && !r_bad;
    assign w_iss_tag.bad  = r_bad;
    assign w_iss_tag.last = w_last_issue;

    // angle indexes
    logic         w_div_valid;
    logic [B-1:0] w_theta;
    logic [B-1:0] w_phi;
    t_vtx_tag     w_div_tag;

    uvs_angle_div #(
        .MAX_SEGMENTS    (MAX_SEGMENTS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_busy),
        .i_ring  (w_iss_ring),
        .i_seg   (w_iss_seg),
        .i_n     (w_n),
        .i_tag   (w_iss_tag),
        .o_valid (w_div_valid),
        .o_theta (w_theta),
        .o_phi   (w_phi),
        .o_tag   (w_div_tag)
    );

    logic signed [15:0] w_st;
    logic signed [15:0] w_ct;
    logic signed [15:0] w_sf;
    logic signed [15:0] w_cf;

    uvs_sincos #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_sc_theta (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (w_theta),
        .o_sin   (w_st),
        .o_cos   (w_ct)
    );

    uvs_sincos #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_sc_phi (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (w_phi),
        .o_sin   (w_sf),
        .o_cos   (w_cf)
    );

    // tags beside the two sincos stages
    logic     r_sc_valid [2];
    t_vtx_tag r_sc_tag   [2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc_valid[0] <= 1'b0;
            r_sc_valid[1] <= 1'b0;
        end else if (w_en) begin
            r_sc_valid[0] <= w_div_valid;
            r_sc_valid[1] <= r_sc_valid[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sc_tag[0] <= w_div_tag;
            r_sc_tag[1] <= r_sc_tag[0];
        end
    end

    // multiply stages: r*sin(t) and r*cos(t), then times cos(f) and sin(f)
    logic signed [RAD_W:0] w_radius_s;
    logic                  r_m1_valid;
    t_vtx_tag              r_m1_tag;
    logic signed [32:0]    r_m1_rs;
    logic signed [32:0]    r_m1_z;
    logic signed [15:0]    r_m1_sf;
    logic signed [15:0]    r_m1_cf;
    logic                  r_m2_valid;
    t_vtx_tag              r_m2_tag;
    logic signed [48:0]    r_m2_x;
    logic signed [48:0]    r_m2_y;
    logic signed [32:0]    r_m2_z;

    assign w_radius_s = $signed({1'b0, r_radius});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_valid <= 1'b0;
            r_m2_valid <= 1'b0;
        end else if (w_en) begin
            r_m1_valid <= r_sc_valid[1];
            r_m2_valid <= r_m1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m1_tag <= r_sc_tag[1];
            r_m1_rs  <= w_radius_s * w_st;
            r_m1_z   <= w_radius_s * w_ct;
            r_m1_sf  <= w_sf;
            r_m1_cf  <= w_cf;
            r_m2_tag <= r_m1_tag;
            r_m2_x   <= r_m1_rs * r_m1_cf;
            r_m2_y   <= r_m1_rs * r_m1_sf;
            r_m2_z   <= r_m1_z;
        end
    end

    // round halves away from zero, then clamp to the 17-bit range
    function automatic logic signed [POS_W-1:0] f_round_sat(input logic signed [48:0] v,
                                                            input int sh);
        logic signed [49:0] half;
        logic signed [49:0] t;
        half = 50'sd1 <<< (sh - 1);
        t    = $signed({v[48], v}) + half - $signed({49'd0, v[48]});
        t    = t >>> sh;
        if (t > 50'sd65535) begin
            return 17'sh0FFFF;
        end else if (t < -50'sd65536) begin
            return 17'sh10000;
        end
        return t[POS_W-1:0];
    endfunction

    // output register
    t_vtx_tag                r_out_tag;
    logic signed [POS_W-1:0] r_out_x;
    logic signed [POS_W-1:0] r_out_y;
    logic signed [POS_W-1:0] r_out_z;
    logic signed [POS_W-1:0] n_out_x;
    logic signed [POS_W-1:0] n_out_y;
    logic signed [POS_W-1:0] n_out_z;

    always_comb begin
        n_out_x = f_round_sat(r_m2_x, 30);
        n_out_y = f_round_sat(r_m2_y, 30);
        n_out_z = f_round_sat(49'(r_m2_z), 15);
        if (r_m2_tag.bad) begin
            n_out_x = '0;
            n_out_y = '0;
            n_out_z = '0;
        end else if (r_m2_tag.pole) begin
            n_out_x = '0;
            n_out_y = '0;
            n_out_z = -w_radius_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_m2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_tag <= r_m2_tag;
            r_out_x   <= n_out_x;
            r_out_y   <= n_out_y;
            r_out_z   <= n_out_z;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out_tag.slot, r_out_z, r_out_y, r_out_x};
    assign o_m_axis_tlast  = r_out_tag.last;
    assign o_m_axis_tuser  = r_out_tag.bad;

    // checks
    a_bad_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_tag.bad) |->
            (r_out_x == '0 && r_out_y == '0 && r_out_z == '0 && r_out_tag.last &&
             r_out_tag.slot == SLOT_FIRST))
        else $error("bad-index item with nonzero payload or without last");

    a_last_on_slot5: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_tag.last && !r_out_tag.bad) |-> (r_out_tag.slot == SLOT_LAST))
        else $error("last vertex flagged on a slot other than five");

    a_accept_starts_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_busy && r_slot == SLOT_FIRST))
        else $error("accepted cell did not start at slot zero");

    a_bad_cell_one_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_bad) |-> (r_slot == SLOT_FIRST))
        else $error("bad cell issued more than one vertex");

endmodule

FILE: hw/rtl/uvs_angle_div.sv
// uvs_angle_div: pipelined rounding divider giving the theta and phi table indexes
// one quotient bit per stage for both angles, divisor 2n shared; depends on uvs_pkg
module uvs_angle_div #(
    parameter int MAX_SEGMENTS    = uvs_pkg::MAX_SEGMENTS_DEF,
    parameter int SINE_TABLE_BITS = uvs_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  logic                                   i_valid,
    input  logic [$clog2(MAX_SEGMENTS+1)-1:0]      i_ring,
    input  logic [$clog2(MAX_SEGMENTS+1)-1:0]      i_seg,
    input  logic [$clog2(MAX_SEGMENTS+1)-1:0]      i_n,
    input  uvs_pkg::t_vtx_tag                      i_tag,
    output logic                                   o_valid,
    output logic [SINE_TABLE_BITS-1:0]             o_theta,
    output logic [SINE_TABLE_BITS-1:0]             o_phi,
    output uvs_pkg::t_vtx_tag                      o_tag
);
    import uvs_pkg::*;

    localparam int NW   = $clog2(MAX_SEGMENTS + 1);
    localparam int B    = SINE_TABLE_BITS;
    localparam int NUMW = NW + B + 2;
    localparam int DW   = NW + 1;

    logic            r_valid [B+1];
    logic [NUMW-1:0] r_rem_t [B+1];
    logic [NUMW-1:0] r_rem_f [B+1];
    logic [B-1:0]    r_q_t   [B+1];
    logic [B-1:0]    r_q_f   [B+1];
    logic [DW-1:0]   r_d     [B+1];
    t_vtx_tag        r_tag   [B+1];

    // theta: (j*T + n) / 2n, phi: (2*i*T + n) / 2n, both floor
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem_t[0] <= (NUMW'(i_ring) << B) + NUMW'(i_n);
            r_rem_f[0] <= (NUMW'(i_seg) << (B + 1)) + NUMW'(i_n);
            r_d[0]     <= {i_n, 1'b0};
            r_q_t[0]   <= '0;
            r_q_f[0]   <= '0;
            r_tag[0]   <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
        end
    end

    for (genvar s = 0; s < B; s++) begin : g_stage
        localparam int K = B - 1 - s;
        logic [NUMW-1:0] w_dsh;
        logic            w_ge_t;
        logic            w_ge_f;
        logic [NUMW-1:0] n_rem_t;
        logic [NUMW-1:0] n_rem_f;

        assign w_dsh   = NUMW'(r_d[s]) << K;
        assign w_ge_t  = r_rem_t[s] >= w_dsh;
        assign w_ge_f  = r_rem_f[s] >= w_dsh;
        assign n_rem_t = w_ge_t ? r_rem_t[s] - w_dsh : r_rem_t[s];
        assign n_rem_f = w_ge_f ? r_rem_f[s] - w_dsh : r_rem_f[s];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem_t[s+1] <= n_rem_t;
                r_rem_f[s+1] <= n_rem_f;
                r_q_t[s+1]   <= {r_q_t[s][B-2:0], w_ge_t};
                r_q_f[s+1]   <= {r_q_f[s][B-2:0], w_ge_f};
                r_d[s+1]     <= r_d[s];
                r_tag[s+1]   <= r_tag[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[s+1] <= r_valid[s];
            end
        end
    end

    assign o_valid = r_valid[B];
    assign o_theta = r_q_t[B];
    assign o_phi   = r_q_f[B];
    assign o_tag   = r_tag[B];

endmodule

FILE: hw/rtl/uvs_sincos.sv
// uvs_sincos: sine and cosine of a table index from a quarter-wave rom, q1.15 signed
// two register stages: quadrant folding, then rom read with sign; depends on uvs_pkg
module uvs_sincos #(
    parameter int SINE_TABLE_BITS = uvs_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [SINE_TABLE_BITS-1:0]  i_angle,
    output logic signed [15:0]          o_sin,
    output logic signed [15:0]          o_cos
);
    import uvs_pkg::*;

    localparam int B    = SINE_TABLE_BITS;
    localparam int QTR  = 2 ** (B - 2);
    localparam int AW   = B - 1;
    localparam int EW   = SINE_MAG_W;
    localparam int ROMW = (QTR + 1) * EW;

    function automatic logic [ROMW-1:0] f_rom();
        logic [ROMW-1:0] rom;
        rom = '0;
        for (int k = 0; k <= QTR; k++) begin
            rom[k*EW +: EW] = f_qsin(k, B);
        end
        return rom;
    endfunction

    localparam logic [ROMW-1:0] QSIN_ROM = f_rom();

    logic [1:0]    w_quad;
    logic [AW-1:0] w_ofs;
    logic [AW-1:0] w_mirror;
    logic [AW-1:0] r_sin_addr;
    logic [AW-1:0] r_cos_addr;
    logic          r_sin_neg;
    logic          r_cos_neg;
    logic [EW-1:0] w_sin_mag;
    logic [EW-1:0] w_cos_mag;
    logic signed [15:0] r_sin;
    logic signed [15:0] r_cos;

    assign w_quad   = i_angle[B-1:B-2];
    assign w_ofs    = AW'(i_angle[B-3:0]);
    assign w_mirror = AW'(QTR) - w_ofs;

    // cosine is the sine one quadrant later
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin_addr <= w_quad[0] ? w_mirror : w_ofs;
            r_cos_addr <= w_quad[0] ? w_ofs : w_mirror;
            r_sin_neg  <= w_quad[1];
            r_cos_neg  <= w_quad[1] ^ w_quad[0];
        end
    end

    assign w_sin_mag = QSIN_ROM[r_sin_addr*EW +: EW];
    assign w_cos_mag = QSIN_ROM[r_cos_addr*EW +: EW];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin <= r_sin_neg ? -$signed({1'b0, w_sin_mag}) : $signed({1'b0, w_sin_mag});
            r_cos <= r_cos_neg ? -$signed({1'b0, w_cos_mag}) : $signed({1'b0, w_cos_mag});
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule
